FILE: sv/css_pkg.sv
// Shared widths, datapath command and status types for the cosine similarity block.
// No dependencies.
package css_pkg;

  localparam int EW = 16;   // element width
  localparam int DW = 45;   // dot sum width, signed
  localparam int NW = 44;   // norm sum width, unsigned
  localparam int PW = 89;   // norm product and squared dot width
  localparam int MW = 128;  // serial multiplier accumulator width
  localparam int BW = 45;   // serial multiplier operand B width
  localparam int QW = 16;   // result magnitude width
  localparam int TW = 17;   // odd trial factor width
  localparam int KW = 4;    // result bit index width

  localparam logic [QW-1:0] M_LIMIT = 16'd32768;
  localparam logic [KW-1:0] K_TOP   = 4'd15;

  typedef enum logic [1:0] {
    MUL_PN,
    MUL_DD,
    MUL_PT,
    MUL_XT
  } mul_sel_e;

  typedef struct packed {
    logic     acc_en;
    logic     mul_load;
    mul_sel_e mul_sel;
    logic     mul_step;
    logic     store_p;
    logic     store_r;
    logic     keep_bit;
    logic     next_bit;
    logic     out_load;
  } css_cmd_t;

  typedef struct packed {
    logic zero;
    logic mul_done;
    logic over;
    logic cmp_le;
    logic last_bit;
    logic out_busy;
  } css_stat_t;

endpackage

FILE: sv/cosine_similarity_stream.sv
// Top level of the streaming cosine similarity block.
// Depends on css_pkg, css_ctrl and css_datapath.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one element pair per
//   transfer, signed Q1.15, with last_i on the final pair of a vector.
//   Pairs without last_i are taken one per cycle; the sums saturate.
//   On the last pair the block stops taking input and computes
//   dot / sqrt(norm_a * norm_b) with a shared serial shift-add multiplier:
//   the norm product and squared dot, then two trial multiplies for each
//   of 16 result bits; how long each multiply runs is set by the operand
//   bit counts.
//   A zero norm skips the search: result 0 with zero_norm_o set.
//   The result waits in an output register; while the receiver stalls,
//   input is taken again, and the next result waits for the register.
//   Reset clears the sums and drops any pending result.
module cosine_similarity_stream import css_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [EW-1:0] elem_a_i,
  input  logic signed [EW-1:0] elem_b_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [EW-1:0] similarity_o,
  output logic                 zero_norm_o,
  output logic                 saturated_o
);

  css_cmd_t  cmd;
  css_stat_t stat;

  css_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  css_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem_a_i     (elem_a_i),
    .elem_b_i     (elem_b_i),
    .last_i       (last_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .similarity_o (similarity_o),
    .zero_norm_o  (zero_norm_o),
    .saturated_o  (saturated_o)
  );

endmodule

FILE: sv/css_ctrl.sv
// Controller for the cosine similarity block: sequences accumulation, the
// serial multiplies and the bitwise result search. Depends on css_pkg.
module css_ctrl import css_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      last_i,
  output logic      in_ready_o,
  input  css_stat_t stat_i,
  output css_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_ACC,
    S_CHK,
    S_MULP,
    S_MULR,
    S_TRIAL,
    S_MULX,
    S_MULY,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_ACC);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_ACC: begin
        cmd_o.acc_en = in_valid_i;
        if (in_valid_i && last_i) state_d = S_CHK;
      end
      S_CHK: begin
        cmd_o.mul_load = 1'b1;
        cmd_o.mul_sel  = MUL_PN;
        state_d = stat_i.zero ? S_OUT : S_MULP;
      end
      S_MULP: begin
        if (stat_i.mul_done) begin
          cmd_o.store_p  = 1'b1;
          cmd_o.mul_load = 1'b1;
          cmd_o.mul_sel  = MUL_DD;
          state_d = S_MULR;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_MULR: begin
        if (stat_i.mul_done) begin
          cmd_o.store_r = 1'b1;
          state_d = S_TRIAL;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_TRIAL: begin
        if (stat_i.over) begin
          cmd_o.next_bit = 1'b1;
          state_d = stat_i.last_bit ? S_OUT : S_TRIAL;
        end else begin
          cmd_o.mul_load = 1'b1;
          cmd_o.mul_sel  = MUL_PT;
          state_d = S_MULX;
        end
      end
      S_MULX: begin
        if (stat_i.mul_done) begin
          cmd_o.mul_load = 1'b1;
          cmd_o.mul_sel  = MUL_XT;
          state_d = S_MULY;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_MULY: begin
        if (stat_i.mul_done) begin
          cmd_o.keep_bit = stat_i.cmp_le;
          cmd_o.next_bit = 1'b1;
          state_d = stat_i.last_bit ? S_OUT : S_TRIAL;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/css_datapath.sv
// Datapath for the cosine similarity block: saturating sums, serial
// shift-add multiplier, result search registers and output register.
// Depends on css_pkg.
module css_datapath import css_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic signed [EW-1:0] elem_a_i,
  input  logic signed [EW-1:0] elem_b_i,
  input  logic                 last_i,
  input  css_cmd_t             cmd_i,
  output css_stat_t            stat_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic signed [EW-1:0] similarity_o,
  output logic                 zero_norm_o,
  output logic                 saturated_o
);

  logic signed [DW-1:0] dot_q, dsn_q;
  logic [NW-1:0]        na_q, nb_q, nas_q, nbs_q;
  logic                 sat_q, sats_q, zero_q;

  logic signed [2*EW-1:0] p_ab, p_aa, p_bb;
  logic signed [DW:0]     d_ext;
  logic [NW:0]            na_ext, nb_ext;
  logic signed [DW-1:0]   d_new;
  logic [NW-1:0]          na_new, nb_new;
  logic                   sat_now;

  assign p_ab = elem_a_i * elem_b_i;
  assign p_aa = elem_a_i * elem_a_i;
  assign p_bb = elem_b_i * elem_b_i;

  assign d_ext  = {dot_q[DW-1], dot_q} + (DW+1)'(p_ab);
  assign na_ext = {1'b0, na_q} + (NW+1)'(p_aa[2*EW-2:0]);
  assign nb_ext = {1'b0, nb_q} + (NW+1)'(p_bb[2*EW-2:0]);

  always_comb begin
    sat_now = 1'b0;
    d_new   = d_ext[DW-1:0];
    na_new  = na_ext[NW-1:0];
    nb_new  = nb_ext[NW-1:0];
    if (d_ext[DW] != d_ext[DW-1]) begin
      sat_now = 1'b1;
      d_new   = d_ext[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    if (na_ext[NW]) begin
      sat_now = 1'b1;
      na_new  = '1;
    end
    if (nb_ext[NW]) begin
      sat_now = 1'b1;
      nb_new  = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (last_i) begin
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
        sat_q <= 1'b0;
      end else begin
        dot_q <= d_new;
        na_q  <= na_new;
        nb_q  <= nb_new;
        sat_q <= sat_q | sat_now;
      end
    end
  end

  // snapshot of the finished vector
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en && last_i) begin
      dsn_q  <= d_new;
      nas_q  <= na_new;
      nbs_q  <= nb_new;
      sats_q <= sat_q | sat_now;
      zero_q <= (na_new == '0) || (nb_new == '0);
    end
  end

  logic [BW-1:0] ad;
  assign ad = dsn_q[DW-1] ? BW'(-dsn_q) : BW'(dsn_q);

  // result search: m is built from the top bit down
  logic [QW-1:0] m_q, mt;
  logic [KW-1:0] k_q;
  logic [TW-1:0] t;

  assign mt = m_q | (QW'(1) << k_q);
  assign t  = {mt, 1'b0} - TW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en && last_i) begin
      m_q <= '0;
      k_q <= K_TOP;
    end else if (cmd_i.next_bit) begin
      if (cmd_i.keep_bit) m_q <= mt;
      k_q <= k_q - KW'(1);
    end
  end

  // serial shift-add multiplier
  logic [MW-1:0] mul_a_q, mul_acc_q, a_sel;
  logic [BW-1:0] mul_b_q, b_sel;
  logic [PW-1:0] p_q, r_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_PN: begin
        a_sel = MW'(nas_q);
        b_sel = BW'(nbs_q);
      end
      MUL_DD: begin
        a_sel = MW'(ad);
        b_sel = ad;
      end
      MUL_PT: begin
        a_sel = MW'(p_q);
        b_sel = BW'(t);
      end
      MUL_XT: begin
        a_sel = mul_acc_q;
        b_sel = BW'(t);
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      mul_a_q   <= a_sel;
      mul_b_q   <= b_sel;
      mul_acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (mul_b_q[0]) mul_acc_q <= mul_acc_q + mul_a_q;
      mul_a_q <= mul_a_q << 1;
      mul_b_q <= mul_b_q >> 1;
    end
    if (cmd_i.store_p) p_q <= mul_acc_q[PW-1:0];
    if (cmd_i.store_r) r_q <= mul_acc_q[PW-1:0];
  end

  // output register
  logic                 out_valid_q;
  logic signed [EW-1:0] sim_q;
  logic                 zn_q, so_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      zn_q <= zero_q;
      so_q <= sats_q;
      if (zero_q) begin
        sim_q <= '0;
      end else if (dsn_q[DW-1]) begin
        sim_q <= -$signed(m_q);
      end else if (m_q > 16'd32767) begin
        sim_q <= 16'sd32767;
      end else begin
        sim_q <= $signed(m_q);
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign zero_norm_o  = zn_q;
  assign saturated_o  = so_q;

  assign stat_o.zero     = zero_q;
  assign stat_o.mul_done = (mul_b_q == '0);
  assign stat_o.over     = (mt > M_LIMIT);
  assign stat_o.cmp_le   = (mul_acc_q <= MW'({r_q, 32'b0}));
  assign stat_o.last_bit = (k_q == '0);
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  a_zero_sim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && zn_q) |-> (sim_q == '0))
    else $error("nonzero similarity with zero norm");
  a_m_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.next_bit |=> (m_q <= M_LIMIT))
    else $error("result magnitude out of range");
  a_no_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_step |-> !stat_o.mul_done)
    else $error("multiplier stepped after completion");

endmodule

FILE: tb/cosine_similarity_stream_test.sv
// Testbench for cosine_similarity_stream: random and directed element pairs, with a
// bit-exact predictor of the saturating sums and the rounded Q1.15 ratio.
// Depends on css_pkg and the cosine_similarity_stream RTL.
`timescale 1ns / 100ps
module cosine_similarity_stream_test;
  import css_pkg::*;

  localparam int IDLE_PCT   = 28;
  localparam int HOLD_LEN   = 3000;
  localparam int STALL_MAX  = 20000;
  localparam int TAIL_WAIT  = 800;
  localparam longint DOT_HI = (64'sd1 <<< 44) - 1;
  localparam longint DOT_LO = -(64'sd1 <<< 44);
  localparam longint unsigned NORM_HI = (64'd1 << 44) - 1;

  typedef struct {
    logic signed [EW-1:0] a;
    logic signed [EW-1:0] b;
    logic                 last;
  } pair_t;

  typedef struct {
    logic signed [EW-1:0] sim;
    logic                 zn;
    logic                 sat;
  } sim_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, last_i;
  logic signed [EW-1:0] elem_a_i, elem_b_i;
  logic out_valid_o, out_ready_i;
  logic signed [EW-1:0] similarity_o;
  logic zero_norm_o, saturated_o;

  cosine_similarity_stream dut (.*);

  pair_t  pairs_q[$];
  sim_t   sims_q[$];
  longint          dot_acc;
  longint unsigned na_acc, nb_acc;
  bit              sat_acc;
  int  errors, checked, n_items, cycle_no, stall_cnt, hold_left;
  bit  in_took, hold_go, hold_started;
  wire quiet = (cycle_no > 3000 && cycle_no < 9000);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic sim_t ratio(longint d, longint unsigned na, longint unsigned nb);
    sim_t r;
    logic [159:0] prod, rhs, tt;
    longint unsigned ad;
    int lo, hi, m;
    r.sim = 0;
    r.zn = 0;
    r.sat = sat_acc;
    if (na == 0 || nb == 0) begin
      r.zn = 1;
      return r;
    end
    ad = d < 0 ? longint'(-d) : longint'(d);
    prod = 160'(na) * 160'(nb);
    rhs = (160'(ad) * 160'(ad)) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      m = (lo + hi + 1) / 2;
      tt = 160'(2 * m - 1);
      if (tt * tt * prod <= rhs) lo = m;
      else hi = m - 1;
    end
    if (d < 0) r.sim = EW'(-lo);
    else r.sim = lo > 32767 ? 16'sd32767 : EW'(lo);
    return r;
  endfunction

  task automatic accumulate(logic signed [EW-1:0] a, logic signed [EW-1:0] b, logic last);
    longint sa, sb, d;
    longint unsigned na, nb;
    sa = a;
    sb = b;
    d = dot_acc + sa * sb;
    na = na_acc + longint'(sa * sa);
    nb = nb_acc + longint'(sb * sb);
    if (d > DOT_HI) begin d = DOT_HI; sat_acc = 1; end
    if (d < DOT_LO) begin d = DOT_LO; sat_acc = 1; end
    if (na > NORM_HI) begin na = NORM_HI; sat_acc = 1; end
    if (nb > NORM_HI) begin nb = NORM_HI; sat_acc = 1; end
    dot_acc = d;
    na_acc = na;
    nb_acc = nb;
    if (last) begin
      sims_q = {sims_q, ratio(d, na, nb)};
      dot_acc = 0;
      na_acc = 0;
      nb_acc = 0;
      sat_acc = 0;
    end
  endtask

  // monitor: check results, then predict from accepted pairs
  always @(posedge clk_i) begin
    sim_t e;
    in_took <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      cycle_no <= cycle_no + 1;
      if (out_valid_o && out_ready_i) begin
        checked++;
        if (sims_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: result with none expected: %0d", similarity_o);
        end else begin
          e = sims_q.pop_front();
          if (e.sim !== similarity_o || e.zn !== zero_norm_o || e.sat !== saturated_o) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: sim exp %0d got %0d, zn exp %0b got %0b, sat exp %0b got %0b",
                       e.sim, similarity_o, e.zn, zero_norm_o, e.sat, saturated_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        n_items++;
        accumulate(elem_a_i, elem_b_i, last_i);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("watchdog: no transfer for %0d cycles", STALL_MAX);
        $display("FAIL cosine_similarity_stream");
        $finish;
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    pair_t p;
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (pairs_q.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        p = pairs_q.pop_front();
        in_valid_i <= 1;
        elem_a_i <= p.a;
        elem_b_i <= p.b;
        last_i <= p.last;
      end else begin
        in_valid_i <= 0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_go && !hold_started) begin
        hold_started <= 1;
        hold_left <= HOLD_LEN;
        out_ready_i <= 0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 0;
      end else begin
        out_ready_i <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic signed [EW-1:0] pick_elem();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return EW'($urandom);
    endcase
  endfunction

  task automatic push(logic signed [EW-1:0] a, logic signed [EW-1:0] b, logic last);
    pair_t p;
    p.a = a;
    p.b = b;
    p.last = last;
    pairs_q = {pairs_q, p};
  endtask

  task automatic push_vector();
    int len, kind;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    kind = $urandom_range(9);
    for (int i = 0; i < len; i++)
      if (kind == 0) push(0, pick_elem(), i == len - 1);
      else if (kind == 1) push(pick_elem(), 0, i == len - 1);
      else if (kind == 2) push(pick_elem(), pick_elem(), $urandom_range(3) == 0);
      else push(pick_elem(), pick_elem(), i == len - 1);
  endtask

  task automatic drain();
    while (pairs_q.size() > 0 || in_valid_i || sims_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int target;
    rst_ni = 0;
    in_valid_i = 0;
    elem_a_i = 0;
    elem_b_i = 0;
    last_i = 0;
    out_ready_i = 0;
    dot_acc = 0;
    na_acc = 0;
    nb_acc = 0;
    sat_acc = 0;
    errors = 0;
    checked = 0;
    n_items = 0;
    cycle_no = 0;
    stall_cnt = 0;
    hold_left = 0;
    in_took = 0;
    hold_go = 0;
    hold_started = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    push(16'sd32767, 16'sd32767, 1);
    push(-16'sd32768, -16'sd32768, 1);
    push(-16'sd32768, 16'sd32767, 1);
    push(16'sd32767, -16'sd32768, 1);
    push(0, 16'sd5, 1);
    push(16'sd5, 0, 1);
    push(0, 0, 1);
    push(16'sd1, 0, 0);
    push(0, 16'sd1, 1);
    push(16'sd1, -16'sd1, 0);
    push(-16'sd1, 16'sd1, 0);
    push(16'sd3, 16'sd3, 1);
    push(16'sd1, 16'sd1, 1);
    push(16'sd100, -16'sd7, 0);
    push(-16'sd3, 16'sd250, 0);
    push(16'sd1, 16'sd32767, 1);
    drain();

    // sender pause done; now stall the receiver while input keeps coming
    hold_go = 1;
    target = n_items + 120;
    while (n_items + pairs_q.size() < target) push_vector();
    drain();

    target = n_items + 720;
    while (n_items + pairs_q.size() < target) push_vector();
    push(16'sd9, 16'sd9, 1);
    drain();

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sims_q.size() > 0) begin
      errors++;
      $display("ERROR: %0d expected results never arrived", sims_q.size());
    end
    $display("Covered %0d element pairs and %0d results: extremes, zero norms,",
             n_items, checked);
    $display("a sender pause, a long receiver stall and random vectors.");
    if (errors == 0) begin
      $display("PASS cosine_similarity_stream");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL cosine_similarity_stream");
    end
    $finish;
  end

endmodule
